// ===== sv/pdlt_pkg.sv =====
package pdlt_pkg;

   localparam int CFG_W      = 7;
   localparam int CFG_NUM    = 8;
   localparam int CFG_IDX_W  = $clog2(CFG_NUM);
   localparam int TICK_W     = 8;
   localparam int BIT_W      = 5;
   localparam int BYTE_W     = 8;
   localparam int SHIFT_W    = 2 * BYTE_W;
   localparam int FRAME_BITS = 16;
   localparam int WIN_W      = TICK_W + 2;

   // link modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RECV = 2'd1;
   localparam logic [1:0] MODE_SEND = 2'd2;

   // send phases
   localparam logic [1:0] PH_SYNC = 2'd0;
   localparam logic [1:0] PH_BIT  = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;

   // request codes
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_EDGE = 2'd1;
   localparam logic [1:0] REQ_SEND = 2'd2;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LOW  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_SYNC_HIGH = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_STOP_LOW  = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_STOP_HIGH = 3'd7;

   // register reset values
   localparam logic [CFG_W-1:0] RST_SYNC_LOW  = 7'd80;
   localparam logic [CFG_W-1:0] RST_SYNC_HIGH = 7'd40;
   localparam logic [CFG_W-1:0] RST_ZERO_LOW  = 7'd10;
   localparam logic [CFG_W-1:0] RST_ZERO_HIGH = 7'd10;
   localparam logic [CFG_W-1:0] RST_ONE_LOW   = 7'd5;
   localparam logic [CFG_W-1:0] RST_ONE_HIGH  = 7'd5;
   localparam logic [CFG_W-1:0] RST_STOP_LOW  = 7'd20;
   localparam logic [CFG_W-1:0] RST_STOP_HIGH = 7'd10;

   // receive tolerance windows, exclusive
   localparam logic [WIN_W-1:0] BIT_MARGIN  = 10'd3;
   localparam logic [WIN_W-1:0] SYNC_MARGIN = 10'd10;

   typedef struct packed {
      logic [CFG_W-1:0] sync_low;
      logic [CFG_W-1:0] sync_high;
      logic [CFG_W-1:0] zero_low;
      logic [CFG_W-1:0] zero_high;
      logic [CFG_W-1:0] one_low;
      logic [CFG_W-1:0] one_high;
      logic [CFG_W-1:0] stop_low;
      logic [CFG_W-1:0] stop_high;
   } cfg_type;

   typedef struct packed {
      logic              line_level;
      logic              send_accepted;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_byte;
      logic [1:0]        link_mode;
   } rsp_type;

endpackage

// ===== sv/pulse_distance_link_transceiver.sv =====
// Half-duplex single-wire transceiver for a pulse-distance code: a frame is a sync
// pulse, a byte and its complement MSB first, and a stop pulse. Each transaction
// is a timer tick, a line edge or a send request and returns exactly one response
// with the driven line level, the link mode and, on the closing edge of a good
// frame, the received byte. One transaction is taken per clock: the state update
// is a single pass of compares and counter steps ahead of the response register,
// and a new transaction is accepted while the response register is empty or being
// drained. Write the timing registers only while the link is idle.
module pulse_distance_link_transceiver (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [pdlt_pkg::BYTE_W-1:0]    req_send_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_line_level,
   output logic                           rsp_send_accepted,
   output logic                           rsp_rx_valid,
   output logic [pdlt_pkg::BYTE_W-1:0]    rsp_rx_byte,
   output logic [1:0]                     rsp_link_mode,
   input  logic                           csr_we,
   input  logic [pdlt_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [pdlt_pkg::CFG_W-1:0]     csr_wdata
);
   import pdlt_pkg::*;

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   pdlt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pdlt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .req_type  (req_type),
      .send_byte (req_send_byte),
      .rsp       (rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response until it is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_level    = rsp_ff.line_level;
   assign rsp_send_accepted = rsp_ff.send_accepted;
   assign rsp_rx_valid      = rsp_ff.rx_valid;
   assign rsp_rx_byte       = rsp_ff.rx_byte;
   assign rsp_link_mode     = rsp_ff.link_mode;

   rx_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rx_valid) |-> (rsp_ff.link_mode == MODE_IDLE))
      else $error("received byte reported while link still busy");

   send_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.send_accepted) |-> (rsp_ff.link_mode == MODE_SEND))
      else $error("accepted send did not enter send mode");

   rx_byte_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.rx_valid) |-> (rsp_ff.rx_byte == '0))
      else $error("received byte nonzero without a good frame");

   load_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

endmodule

// ===== sv/pdlt_csr.sv =====
module pdlt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [pdlt_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [pdlt_pkg::CFG_W-1:0]     csr_wdata,
   output pdlt_pkg::cfg_type              cfg
);
   import pdlt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CFG_SYNC_LOW:  cfg_in.sync_low  = csr_wdata;
            CFG_SYNC_HIGH: cfg_in.sync_high = csr_wdata;
            CFG_ZERO_LOW:  cfg_in.zero_low  = csr_wdata;
            CFG_ZERO_HIGH: cfg_in.zero_high = csr_wdata;
            CFG_ONE_LOW:   cfg_in.one_low   = csr_wdata;
            CFG_ONE_HIGH:  cfg_in.one_high  = csr_wdata;
            CFG_STOP_LOW:  cfg_in.stop_low  = csr_wdata;
            CFG_STOP_HIGH: cfg_in.stop_high = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_low  <= RST_SYNC_LOW;
         cfg_ff.sync_high <= RST_SYNC_HIGH;
         cfg_ff.zero_low  <= RST_ZERO_LOW;
         cfg_ff.zero_high <= RST_ZERO_HIGH;
         cfg_ff.one_low   <= RST_ONE_LOW;
         cfg_ff.one_high  <= RST_ONE_HIGH;
         cfg_ff.stop_low  <= RST_STOP_LOW;
         cfg_ff.stop_high <= RST_STOP_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/pdlt_engine.sv =====
module pdlt_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  pdlt_pkg::cfg_type           cfg,
   input  logic                        accept,
   input  logic [1:0]                  req_type,
   input  logic [pdlt_pkg::BYTE_W-1:0] send_byte,
   output pdlt_pkg::rsp_type           rsp
);
   import pdlt_pkg::*;

   logic [1:0]         link_state_ff, link_state_in;
   logic [1:0]         send_phase_ff, send_phase_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [BIT_W-1:0]   bit_count_ff, bit_count_in;
   logic [SHIFT_W-1:0] frame_shift_ff, frame_shift_in;
   logic               line_drive_ff, line_drive_in;

   logic [TICK_W-1:0]  sync_tot, bit_lo, bit_tot, stop_tot, tick_base;
   logic               bit_one;
   logic [WIN_W-1:0]   t_win, zero_tot, one_tot, sync_win_tot;
   logic               in_zero, in_one, in_sync;
   logic               accepted, valid;
   logic [BYTE_W-1:0]  rx;

   always_comb begin
      sync_tot = TICK_W'(cfg.sync_low) + TICK_W'(cfg.sync_high);
      bit_one  = frame_shift_ff[SHIFT_W-1];
      bit_lo   = bit_one ? TICK_W'(cfg.one_low) : TICK_W'(cfg.zero_low);
      bit_tot  = bit_lo + (bit_one ? TICK_W'(cfg.one_high) : TICK_W'(cfg.zero_high));
      stop_tot = TICK_W'(cfg.stop_low) + TICK_W'(cfg.stop_high);

      // interval windows, compared without wrap
      t_win        = WIN_W'(tick_count_ff);
      zero_tot     = WIN_W'(cfg.zero_low) + WIN_W'(cfg.zero_high);
      one_tot      = WIN_W'(cfg.one_low) + WIN_W'(cfg.one_high);
      sync_win_tot = WIN_W'(cfg.sync_low) + WIN_W'(cfg.sync_high);
      in_zero = (t_win < zero_tot + BIT_MARGIN) && (t_win + BIT_MARGIN > zero_tot);
      in_one  = (t_win < one_tot + BIT_MARGIN) && (t_win + BIT_MARGIN > one_tot);
      in_sync = (t_win < sync_win_tot + SYNC_MARGIN) &&
                (t_win + SYNC_MARGIN > sync_win_tot);
   end

   always_comb begin
      link_state_in  = link_state_ff;
      send_phase_in  = send_phase_ff;
      tick_count_in  = tick_count_ff;
      bit_count_in   = bit_count_ff;
      frame_shift_in = frame_shift_ff;
      line_drive_in  = line_drive_ff;
      tick_base      = tick_count_ff;
      accepted       = 1'b0;
      valid          = 1'b0;
      rx             = '0;

      if (accept) begin
         unique case (req_type)
            REQ_TICK: begin
               if (link_state_ff == MODE_SEND) begin
                  unique case (send_phase_ff)
                     PH_SYNC: begin
                        if (tick_count_ff == '0) begin
                           line_drive_in = 1'b0;
                        end else if (tick_count_ff == TICK_W'(cfg.sync_low)) begin
                           line_drive_in = 1'b1;
                        end else if (tick_count_ff == sync_tot) begin
                           line_drive_in = 1'b0;
                           tick_base     = '0;
                           bit_count_in  = '0;
                           send_phase_in = PH_BIT;
                        end
                     end
                     PH_BIT: begin
                        if (tick_count_ff == bit_lo) begin
                           line_drive_in = 1'b1;
                        end else if (tick_count_ff == bit_tot) begin
                           line_drive_in  = 1'b0;
                           tick_base      = '0;
                           bit_count_in   = bit_count_ff + 1'b1;
                           frame_shift_in = {frame_shift_ff[SHIFT_W-2:0], 1'b0};
                        end
                        if (bit_count_in == BIT_W'(FRAME_BITS)) begin
                           send_phase_in = PH_STOP;
                        end
                     end
                     default: begin
                        if (tick_count_ff == TICK_W'(cfg.stop_low)) begin
                           line_drive_in = 1'b1;
                        end else if (tick_count_ff == stop_tot) begin
                           tick_base     = '0;
                           link_state_in = MODE_IDLE;
                        end
                     end
                  endcase
                  tick_count_in = tick_base + 1'b1;
               end else if (link_state_ff == MODE_RECV) begin
                  tick_count_in = tick_count_ff + 1'b1;
               end
            end
            REQ_EDGE: begin
               if (link_state_ff == MODE_IDLE) begin
                  link_state_in = MODE_RECV;
                  bit_count_in  = '0;
                  tick_count_in = '0;
               end else if (link_state_ff == MODE_RECV) begin
                  frame_shift_in = {frame_shift_ff[SHIFT_W-2:0], 1'b0};
                  bit_count_in   = bit_count_ff + 1'b1;
                  if (in_zero) begin
                     frame_shift_in[0] = 1'b0;
                  end else if (in_one) begin
                     frame_shift_in[0] = 1'b1;
                  end else if (in_sync) begin
                     bit_count_in = '0;
                  end else begin
                     // abort: the zero stays shifted in
                     link_state_in = MODE_IDLE;
                  end
                  if (bit_count_in == BIT_W'(FRAME_BITS)) begin
                     link_state_in = MODE_IDLE;
                     if ((frame_shift_in[SHIFT_W-1:BYTE_W] ^ frame_shift_in[BYTE_W-1:0])
                         == {BYTE_W{1'b1}}) begin
                        valid = 1'b1;
                        rx    = frame_shift_in[SHIFT_W-1:BYTE_W];
                     end
                  end
                  tick_count_in = '0;
               end
            end
            REQ_SEND: begin
               if (link_state_ff == MODE_IDLE) begin
                  link_state_in  = MODE_SEND;
                  frame_shift_in = {send_byte, ~send_byte};
                  tick_count_in  = '0;
                  send_phase_in  = PH_SYNC;
                  accepted       = 1'b1;
               end
            end
            default: begin
               // no operation
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff  <= MODE_IDLE;
         send_phase_ff  <= PH_SYNC;
         tick_count_ff  <= '0;
         bit_count_ff   <= '0;
         frame_shift_ff <= '0;
         line_drive_ff  <= 1'b1;
      end else begin
         link_state_ff  <= link_state_in;
         send_phase_ff  <= send_phase_in;
         tick_count_ff  <= tick_count_in;
         bit_count_ff   <= bit_count_in;
         frame_shift_ff <= frame_shift_in;
         line_drive_ff  <= line_drive_in;
      end
   end

   always_comb begin
      rsp.line_level    = line_drive_in;
      rsp.send_accepted = accepted;
      rsp.rx_valid      = valid;
      rsp.rx_byte       = rx;
      rsp.link_mode     = link_state_in;
   end

   bit_count_bound: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BIT_W'(FRAME_BITS))
      else $error("bit count ran past frame length");

   send_start_clear: assert property (@(posedge clock) disable iff (reset)
      accepted |=> (tick_count_ff == '0) && (send_phase_ff == PH_SYNC)
                   && (link_state_ff == MODE_SEND))
      else $error("send start did not set up the sync phase");

endmodule
